// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the calendar alarm checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted (active-low reset).
`define CAM_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: %m");

// Clocked check that also holds through reset.
`define CAM_ASSERT(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed: %m");

`endif

// ===== design/cam_pkg.sv =====
// ----------------------------------------------------------------------------
// cam_pkg
// Shared constants and types for the calendar alarm matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cam_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MASK_W     = 16;
    localparam int S_DATA_W   = 64;
    localparam int S_USER_W   = 2;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    // s_tdata layout, lowest field in the lowest bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [3:0]  end_month;
        logic [4:0]  end_day;
        logic [13:0] year;
        logic [3:0]  date_month;
        logic [4:0]  date_day;
        logic [2:0]  weekday;
        logic [6:0]  days_mask;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [3:0]  slot;
    } in_word_t;

    // one calendar date: day [4:0], month [8:5], year [22:9]
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    typedef struct packed {
        logic       valid;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [6:0] day_mask;
        logic [4:0] win_start_day;
        logic [3:0] win_start_month;
        logic [4:0] win_end_day;
        logic [3:0] win_end_month;
        logic       win_on;
        date_t      last_date;
        logic       last_known;
    } slot_entry_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] weekday;
        date_t      today;
    } tick_info_t;

    typedef enum logic [1:0] {
        TBL_NOP   = 2'd0,
        TBL_WRITE = 2'd1,
        TBL_CLEAR = 2'd2,
        TBL_FIRE  = 2'd3
    } tbl_op_t;

    // command into the slot table; entry fields used by TBL_WRITE,
    // fire_date used by TBL_FIRE
    typedef struct packed {
        tbl_op_t               op;
        logic [SLOT_IDX_W-1:0] idx;
        slot_entry_t           entry;
        date_t                 fire_date;
    } tbl_cmd_t;

endpackage

// ===== design/cam_slot_store.sv =====
// ----------------------------------------------------------------------------
// cam_slot_store
// Alarm slot table: one command port, one indexed read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cam_slot_store
    import cam_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tbl_cmd_t              cmd,
    input  logic [SLOT_IDX_W-1:0] rd_idx,
    output slot_entry_t           rd_entry
);

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] known_reg;
    slot_entry_t      slot_reg [SLOTS];

    // control bits: reset clears the whole table at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            known_reg <= '0;
        end else begin
            case (cmd.op)
                TBL_WRITE: begin
                    valid_reg[cmd.idx] <= 1'b1;
                    known_reg[cmd.idx] <= 1'b0;
                end
                TBL_CLEAR: begin
                    valid_reg[cmd.idx] <= 1'b0;
                    known_reg[cmd.idx] <= 1'b0;
                end
                TBL_FIRE: begin
                    known_reg[cmd.idx] <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        case (cmd.op)
            TBL_WRITE: begin
                slot_reg[cmd.idx] <= cmd.entry;
            end
            TBL_FIRE: begin
                slot_reg[cmd.idx].last_date <= cmd.fire_date;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        rd_entry            = slot_reg[rd_idx];
        rd_entry.valid      = valid_reg[rd_idx];
        rd_entry.last_known = known_reg[rd_idx];
    end

endmodule

// ===== design/cam_match_unit.sv =====
// ----------------------------------------------------------------------------
// cam_match_unit
// Shared compare unit: decides whether one slot fires on the current tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cam_match_unit
    import cam_pkg::*;
(
    input  slot_entry_t entry,
    input  tick_info_t  tick,
    output logic        fire
);

    logic       wday_ok;
    logic       after_start;
    logic       before_end;
    logic       in_window;
    logic       time_ok;
    logic       same_date;
    logic [2:0] wday_bit;

    always_comb begin
        wday_bit = tick.weekday - 3'd1;
        // weekday zero only passes an empty mask
        wday_ok = (entry.day_mask == '0) ||
                  ((tick.weekday != 3'd0) && entry.day_mask[wday_bit]);

        after_start = (tick.today.month > entry.win_start_month) ||
                      ((tick.today.month == entry.win_start_month) &&
                       (tick.today.day >= entry.win_start_day));
        before_end  = (tick.today.month < entry.win_end_month) ||
                      ((tick.today.month == entry.win_end_month) &&
                       (tick.today.day <= entry.win_end_day));
        // wrap over year end when start month is past end month
        in_window = (after_start && before_end) ||
                    ((entry.win_start_month > entry.win_end_month) &&
                     (after_start || before_end));

        time_ok   = (entry.hour == tick.hour) && (entry.minute == tick.minute);
        same_date = entry.last_known && (entry.last_date == tick.today);

        fire = entry.valid && wday_ok && (!entry.win_on || in_window) &&
               time_ok && !same_date;
    end

endmodule

// ===== design/calendar_alarm_matcher.sv =====
// ----------------------------------------------------------------------------
// calendar_alarm_matcher
// Alarm slot table matched against date and time words, one slot per cycle.
// ----------------------------------------------------------------------------
// Each input word is a tick, a slot write or a slot clear (s_tuser). Every
// word yields exactly one output word holding fired_mask, zero for writes
// and clears. A tick walks the table one slot per clock through a single
// compare unit in the scan state, then the done state loads the output
// register; a write or clear goes straight to the done state. s_tready is
// low while a word is in work. The result sits in an output register, so
// the next word may be taken while the previous result still waits.
// A slot fires at most once per calendar date; writing a slot forgets that.
`timescale 1ns / 1ps

module calendar_alarm_matcher
    import cam_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // slave side
    input  logic                s_tvalid,
    output logic                s_tready,
    // action [1:0]
    input  logic [S_USER_W-1:0] s_tuser,
    // slot [3:0], hour [8:4], minute [14:9], days_mask [21:15],
    // weekday [24:22], date_day [29:25], date_month [33:30],
    // year [47:34], end_day [52:48], end_month [56:53], zero pad above
    input  logic [S_DATA_W-1:0] s_tdata,
    // master side
    output logic                m_tvalid,
    input  logic                m_tready,
    // fired_mask [15:0]
    output logic [MASK_W-1:0]   m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_IDX_W-1:0] idx_reg, idx_next;
    logic [MASK_W-1:0]     fired_reg, fired_next;
    tick_info_t            tick_reg, tick_next;
    logic                  m_valid_reg, m_valid_next;
    logic [MASK_W-1:0]     m_data_reg, m_data_next;

    in_word_t    in_word;
    action_t     action;
    logic        s_accept;
    logic        slot_ok;
    logic        out_load;
    logic        fire;
    tbl_cmd_t    cmd;
    slot_entry_t rd_entry;

    assign in_word = in_word_t'(s_tdata);
    assign action  = action_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    // writes and clears beyond the table are dropped
    assign slot_ok  = (int'(in_word.slot) < SLOTS);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // table command: write/clear at accept, fire update during the scan
    always_comb begin
        cmd                       = '0;
        cmd.op                    = TBL_NOP;
        cmd.idx                   = idx_reg;
        cmd.fire_date             = tick_reg.today;
        cmd.entry.valid           = 1'b1;
        cmd.entry.hour            = in_word.hour;
        cmd.entry.minute          = in_word.minute;
        cmd.entry.day_mask        = in_word.days_mask;
        cmd.entry.win_start_day   = in_word.date_day;
        cmd.entry.win_start_month = in_word.date_month;
        cmd.entry.win_end_day     = in_word.end_day;
        cmd.entry.win_end_month   = in_word.end_month;
        cmd.entry.win_on          = (in_word.date_month != '0) &&
                                    (in_word.end_month != '0);
        if (s_accept && slot_ok) begin
            cmd.idx = SLOT_IDX_W'(in_word.slot);
            case (action)
                ACT_WRITE: cmd.op = TBL_WRITE;
                ACT_CLEAR: cmd.op = TBL_CLEAR;
                default:   cmd.op = TBL_NOP;
            endcase
        end else if ((state_reg == ST_SCAN) && fire) begin
            cmd.op = TBL_FIRE;
        end
    end

    cam_slot_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_idx   (idx_reg),
        .rd_entry (rd_entry)
    );

    cam_match_unit u_match (
        .entry (rd_entry),
        .tick  (tick_reg),
        .fire  (fire)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        fired_next = fired_reg;
        tick_next  = tick_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    idx_next   = '0;
                    fired_next = '0;
                    tick_next.hour    = in_word.hour;
                    tick_next.minute  = in_word.minute;
                    tick_next.weekday = in_word.weekday;
                    tick_next.today   = {in_word.year, in_word.date_month,
                                         in_word.date_day};
                    state_next = (action == ACT_TICK) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                // slots past the mask width never show up in the result
                fired_next = fired_reg | (MASK_W'(fire) << idx_reg);
                idx_next   = idx_reg + SLOT_IDX_W'(1);
                if (idx_reg == SLOT_IDX_W'(SLOTS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = fired_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        fired_reg  <= fired_next;
        tick_reg   <= tick_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== design/cam_checker.sv =====
// ----------------------------------------------------------------------------
// cam_checker
// Port-level checks for the calendar alarm matcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cam_checker
    import cam_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_USER_W-1:0] s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [MASK_W-1:0]   m_tdata
);

    logic s_acc;
    logic s_ctl;

    assign s_acc = s_tvalid && s_tready;
    assign s_ctl = (s_tuser == ACT_WRITE) || (s_tuser == ACT_CLEAR);

    // a stalled result holds
    `CAM_ASSERT_RST(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // reset empties the output register
    `CAM_ASSERT(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

    // busy right after taking a word
    `CAM_ASSERT_RST(a_busy_after_accept, aclk, aresetn, s_acc |=> !s_tready)

    // a write or clear answers a zero mask through the done state and the output register when the output is free
    `CAM_ASSERT_RST(a_ctl_zero, aclk, aresetn, s_acc && s_ctl && !m_tvalid |-> ##2 (m_tvalid && m_tdata == '0))

endmodule

bind calendar_alarm_matcher cam_checker u_cam_checker (.*);
